// ===== rtl/mspt_pkg.sv =====
// Shared types and codes for the multi-slot periodic timer table.
package mspt_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_CREATE   = 3'd1;
    localparam logic [2:0] CMD_START    = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_STOP_ALL = 3'd4;
    localparam logic [2:0] CMD_QUERY    = 3'd5;

    localparam logic [1:0] EV_ACK      = 2'd0;
    localparam logic [1:0] EV_FIRE     = 2'd1;
    localparam logic [1:0] EV_COMPLETE = 2'd2;
    localparam logic [1:0] EV_ERROR    = 2'd3;

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_PENDING = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot_id;
        logic [31:0] now_ticks;
        logic [30:0] period;
        logic [30:0] repeat_limit;
    } mspt_req_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [3:0]  slot_out;
        logic [31:0] fire_total;
        logic [30:0] lateness;
        logic [1:0]  slot_status;
        logic        last;
    } mspt_rsp_t;

    typedef struct packed {
        logic [30:0] period;
        logic [30:0] repeats;
        logic [31:0] fired;
        logic [31:0] deadline;
    } mspt_entry_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic commit;
        logic second;
        logic advance;
        logic flush;
    } mspt_ctl_t;

    typedef struct packed {
        logic tick_same;
        logic sweep;
        logic need_mul;
        logic blocked;
        logic found;
        logic idx_last;
        logic flush_block;
    } mspt_sts_t;

endpackage

// ===== rtl/mspt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mspt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mspt_datapath.sv =====
// Datapath: slot status flops, slot parameter RAM, event holding and output registers.
module mspt_datapath import mspt_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  mspt_req_t req,
    input  mspt_ctl_t ctl,
    output mspt_sts_t sts,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output mspt_rsp_t rsp
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(MAX_RESULTS + 1);

    function automatic mspt_rsp_t make_rsp(logic [1:0] kind, logic [3:0] slot,
                                           logic [31:0] total, logic [30:0] late,
                                           logic [1:0] status);
        mspt_rsp_t r;
        r.event_kind  = kind;
        r.slot_out    = slot;
        r.fire_total  = total;
        r.lateness    = late;
        r.slot_status = status;
        r.last        = 1'b0;
        return r;
    endfunction

    // command registers
    logic [2:0]  cmd_reg;
    logic [3:0]  id_reg;
    logic [31:0] now_reg;
    logic [30:0] per_reg;
    logic [30:0] lim_reg;
    logic [IW-1:0] idx_reg;
    logic [31:0] prev_reg;
    logic [31:0] prod_reg;
    logic [1:0]  st_reg [SLOT_COUNT];
    logic        held_valid_reg;
    mspt_rsp_t   held_reg;
    logic        out_valid_reg;
    mspt_rsp_t   out_reg;
    logic [CW-1:0] cnt_reg;

    logic [IW+3:0] req_id_wide;
    logic [IW+3:0] idx_wide;
    logic          req_id_ok;
    logic          id_valid;
    logic          req_sweep;
    logic [IW-1:0] load_idx;
    logic [3:0]    idx_slot;
    logic [IW-1:0] rd_addr;
    logic [1:0]    cur_st;
    mspt_entry_t   ent;
    mspt_entry_t   wr_ent;
    logic [$bits(mspt_entry_t)-1:0] ram_rdata;
    logic [31:0]   dt;
    logic          ev_valid;
    mspt_rsp_t     ev;
    logic          st_we;
    logic [1:0]    st_new;
    logic          ram_we;
    logic          found;
    logic          need_mul;
    logic          cap;
    logic          out_free;
    logic          commit_take;
    logic          out_push_ev;
    logic          flush_push;
    logic          out_push;
    mspt_rsp_t     flush_rsp;

    assign req_id_wide = {{IW{1'b0}}, req.slot_id};
    assign idx_wide    = {4'd0, idx_reg};
    assign req_id_ok   = 32'(req.slot_id) < 32'(SLOT_COUNT);
    assign id_valid    = 32'(id_reg) < 32'(SLOT_COUNT);
    assign req_sweep   = (req.command == CMD_TICK) || (req.command == CMD_CREATE)
                      || (req.command == CMD_STOP_ALL);
    assign load_idx    = (req_sweep || !req_id_ok) ? '0 : req_id_wide[IW-1:0];
    assign idx_slot    = idx_wide[3:0];

    assign sts.idx_last = idx_reg == IW'(SLOT_COUNT - 1);
    assign sts.sweep    = (cmd_reg == CMD_TICK) || (cmd_reg == CMD_CREATE)
                       || (cmd_reg == CMD_STOP_ALL);
    assign sts.tick_same = (cmd_reg == CMD_TICK) && (now_reg == prev_reg);

    // read the next slot while the current one is written back
    assign rd_addr = ctl.advance ? idx_reg + 1'b1 : idx_reg;
    assign cur_st  = st_reg[idx_reg];
    assign ent     = mspt_entry_t'(ram_rdata);
    assign dt      = now_reg - ent.deadline;

    mspt_ram #(
        .WIDTH ($bits(mspt_entry_t)),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.commit && ram_we),
        .waddr (idx_reg),
        .wdata (wr_ent),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ev_valid = 1'b0;
        ev       = make_rsp(EV_ACK, 4'd0, 32'd0, 31'd0, ST_FREE);
        st_we    = 1'b0;
        st_new   = cur_st;
        ram_we   = 1'b0;
        wr_ent   = ent;
        found    = 1'b0;
        need_mul = 1'b0;
        case (cmd_reg)
            CMD_TICK:
            begin
                if (cur_st == ST_RUNNING)
                begin
                    if (ent.repeats == 31'd0 || ent.fired < {1'b0, ent.repeats})
                    begin
                        if (!dt[31])
                        begin
                            ram_we          = 1'b1;
                            wr_ent.fired    = ent.fired + 32'd1;
                            wr_ent.deadline = ent.deadline + {1'b0, ent.period};
                            ev_valid        = 1'b1;
                            ev = make_rsp(EV_FIRE, idx_slot, ent.fired + 32'd1,
                                          dt[30:0], ST_RUNNING);
                        end
                    end
                    else
                    begin
                        st_we    = 1'b1;
                        st_new   = ST_FREE;
                        ev_valid = 1'b1;
                        ev = make_rsp(EV_COMPLETE, idx_slot, ent.fired, 31'd0, ST_FREE);
                    end
                end
                else if (cur_st == ST_PENDING)
                begin
                    st_we  = 1'b1;
                    st_new = ST_FREE;
                end
            end
            CMD_CREATE:
            begin
                if (cur_st == ST_FREE)
                begin
                    found    = 1'b1;
                    st_we    = 1'b1;
                    st_new   = ST_STOPPED;
                    ram_we   = 1'b1;
                    wr_ent.period   = per_reg;
                    wr_ent.repeats  = lim_reg;
                    wr_ent.fired    = 32'd0;
                    wr_ent.deadline = 32'd0;
                    ev_valid = 1'b1;
                    ev = make_rsp(EV_ACK, idx_slot, 32'd0, 31'd0, ST_STOPPED);
                end
                else if (sts.idx_last)
                begin
                    ev_valid = 1'b1;
                    ev = make_rsp(EV_ERROR, 4'd0, 32'd0, 31'd0, ST_FREE);
                end
            end
            CMD_STOP_ALL:
            begin
                if (cur_st != ST_FREE)
                begin
                    st_we    = 1'b1;
                    st_new   = ST_FREE;
                    ev_valid = 1'b1;
                    ev = make_rsp(EV_COMPLETE, idx_slot, ent.fired, 31'd0, ST_FREE);
                end
            end
            CMD_START:
            begin
                if (!id_valid || cur_st == ST_FREE)
                begin
                    ev_valid = 1'b1;
                    ev = make_rsp(EV_ERROR, id_reg, 32'd0, 31'd0, ST_FREE);
                end
                else if (ctl.second)
                begin
                    st_we           = 1'b1;
                    st_new          = ST_RUNNING;
                    ram_we          = 1'b1;
                    wr_ent.deadline = now_reg + prod_reg;
                    ev_valid        = 1'b1;
                    ev = make_rsp(EV_ACK, id_reg, ent.fired, 31'd0, ST_RUNNING);
                end
                else
                begin
                    need_mul = 1'b1;
                end
            end
            CMD_STOP:
            begin
                ev_valid = 1'b1;
                if (!id_valid || cur_st == ST_FREE)
                begin
                    ev = make_rsp(EV_ERROR, id_reg, 32'd0, 31'd0, ST_FREE);
                end
                else
                begin
                    st_we  = 1'b1;
                    st_new = ST_PENDING;
                    ev = make_rsp(EV_COMPLETE, id_reg, ent.fired, 31'd0, ST_PENDING);
                end
            end
            CMD_QUERY:
            begin
                ev_valid = 1'b1;
                if (!id_valid)
                begin
                    ev = make_rsp(EV_ERROR, id_reg, 32'd0, 31'd0, ST_FREE);
                end
                else if (cur_st == ST_FREE)
                begin
                    ev = make_rsp(EV_ACK, id_reg, 32'd0, 31'd0, ST_FREE);
                end
                else
                begin
                    ev = make_rsp(EV_ACK, id_reg, ent.fired, 31'd0, cur_st);
                end
            end
            default:
            begin
                ev_valid = 1'b1;
                ev = make_rsp(EV_ERROR, id_reg, 32'd0, 31'd0, ST_FREE);
            end
        endcase
    end

    // drop events beyond the result limit; the state still changes
    assign cap         = cnt_reg == CW'(MAX_RESULTS);
    assign out_free    = !out_valid_reg || !rsp_stall;
    assign commit_take = ctl.commit && ev_valid && !cap;
    assign out_push_ev = commit_take && held_valid_reg;
    assign flush_push  = held_valid_reg || ((cmd_reg == CMD_STOP_ALL) && (cnt_reg == '0));
    assign out_push    = out_push_ev || (ctl.flush && flush_push);

    always_comb
    begin
        flush_rsp = held_valid_reg ? held_reg
                                   : make_rsp(EV_ACK, 4'd0, 32'd0, 31'd0, ST_FREE);
        flush_rsp.last = 1'b1;
    end

    assign sts.found       = found;
    assign sts.need_mul    = need_mul;
    assign sts.blocked     = ev_valid && !cap && held_valid_reg && !out_free;
    assign sts.flush_block = flush_push && !out_free;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req.command;
            id_reg  <= req.slot_id;
            now_reg <= req.now_ticks;
            per_reg <= req.period;
            lim_reg <= req.repeat_limit;
            idx_reg <= load_idx;
        end
        else if (ctl.advance)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        prod_reg <= {1'b0, ent.period} * (ent.fired + 32'd1);
        if (commit_take)
        begin
            held_reg <= ev;
        end
        if (out_push_ev)
        begin
            out_reg <= held_reg;
        end
        else if (ctl.flush && flush_push)
        begin
            out_reg <= flush_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                st_reg[i] <= ST_FREE;
            end
            prev_reg       <= 32'd0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.prep && cmd_reg == CMD_TICK)
            begin
                prev_reg <= now_reg;
            end
            if (ctl.commit && st_we)
            begin
                st_reg[idx_reg] <= st_new;
            end
            if (ctl.load)
            begin
                cnt_reg <= '0;
            end
            else if (commit_take)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.flush)
            begin
                held_valid_reg <= 1'b0;
            end
            else if (commit_take)
            begin
                held_valid_reg <= 1'b1;
            end
            if (out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== rtl/mspt_ctrl.sv =====
// Controller: sequences load, slot sweep, start multiply and final flush.
module mspt_ctrl import mspt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  mspt_sts_t sts,
    output mspt_ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_EVAL,
        S_MUL,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                ctl.prep   = 1'b1;
                state_next = sts.tick_same ? S_IDLE : S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.need_mul)
                begin
                    state_next = S_MUL;
                end
                else if (!sts.blocked)
                begin
                    ctl.commit = 1'b1;
                    if (!sts.sweep || sts.found || sts.idx_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        ctl.advance = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                ctl.commit = 1'b1;
                ctl.second = 1'b1;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!sts.flush_block)
                begin
                    ctl.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= state_next != S_IDLE;
        end
    end

    assign req_stall = stall_reg;

endmodule

// ===== rtl/multi_slot_periodic_timer_table.sv =====
// Top level of the multi-slot periodic timer table.
//
// Request channel (req_valid, req_stall, req): one command per transfer:
// tick, create, start, stop, stop-all or query. Response channel
// (rsp_valid, rsp_stall, rsp): the events a command causes, in slot order,
// with last set on the final one. A tick at an unchanged time, or one that
// fires nothing, gives no response.
// Sequencing: one command at a time. A tick, create or stop-all walks the
// slot table one slot per cycle through the parameter RAM unless a stalled
// response holds it (create stops at the first free slot). Start, stop and
// query evaluate only their own slot; start passes through a further state
// for the deadline multiply. The last response is registered in the flush
// state after the sweep ends; the next command is accepted while it waits.
// Reset frees every slot and clears the last tick time; no clearing pass.
// A stalled response holds the sweep on the slot that has the next event;
// the request side stays stalled until the command is finished.
module multi_slot_periodic_timer_table import mspt_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  mspt_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output mspt_rsp_t rsp
);

    mspt_ctl_t ctl;
    mspt_sts_t sts;

    mspt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    mspt_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== tb/sv/multi_slot_periodic_timer_table_tb.sv =====
// Self-checking testbench for the multi-slot periodic timer table.
module multi_slot_periodic_timer_table_tb;
    import mspt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 350;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 10;
    localparam int CYCLE_LIMIT  = 1_500_000;

    // Command codes the block does not define; both must give an error event.
    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;

    typedef struct packed {
        logic      hold;
        mspt_req_t req;
    } timer_cmd_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    mspt_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    mspt_rsp_t rsp;

    multi_slot_periodic_timer_table #(.SLOT_COUNT(SLOTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Timer table as the block should hold it.
    logic [1:0]  tbl_state    [SLOTS] = '{default: ST_FREE};
    logic [30:0] tbl_period   [SLOTS] = '{default: '0};
    logic [30:0] tbl_limit    [SLOTS] = '{default: '0};
    logic [31:0] tbl_fired    [SLOTS] = '{default: '0};
    logic [31:0] tbl_deadline [SLOTS] = '{default: '0};
    logic [31:0] last_tick_time = '0;

    mspt_rsp_t  awaited_events [$];
    timer_cmd_t cmd_queue [$];

    int mismatches      = 0;
    int sent_count      = 0;
    int checked_events  = 0;
    int fire_events     = 0;
    int complete_events = 0;
    int error_events    = 0;
    int cycle_count     = 0;
    int calm_cycles     = 0;
    int send_gap        = 0;
    int stall_left      = 0;
    int issued_items    = 0;
    logic [31:0] gen_now       = '0;
    logic [31:0] gen_last_tick = '0;
    timer_cmd_t  next_cmd;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic mspt_rsp_t make_event(input logic [1:0] kind, input int slot,
                                             input logic [31:0] total,
                                             input logic [30:0] late,
                                             input logic [1:0] status);
        mspt_rsp_t ev;
        ev.event_kind  = kind;
        ev.slot_out    = 4'(slot);
        ev.fire_total  = total;
        ev.lateness    = late;
        ev.slot_status = status;
        ev.last        = 1'b0;
        return ev;
    endfunction

    // Apply one accepted command to the table and queue the events it causes.
    function automatic void timer_table_apply(input mspt_req_t r);
        mspt_rsp_t   evs [$];
        logic [31:0] dt;
        logic [31:0] k;
        int          id;
        int          found;
        bit          in_range;
        id       = int'(r.slot_id);
        in_range = id < SLOTS;
        case (r.command)
            CMD_TICK:
            begin
                if (r.now_ticks != last_tick_time)
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (tbl_state[s] == ST_RUNNING)
                        begin
                            if (tbl_limit[s] == '0 || tbl_fired[s] < {1'b0, tbl_limit[s]})
                            begin
                                dt = r.now_ticks - tbl_deadline[s];
                                if (!dt[31])
                                begin
                                    tbl_fired[s]    = tbl_fired[s] + 1;
                                    tbl_deadline[s] = tbl_deadline[s] + {1'b0, tbl_period[s]};
                                    evs.push_back(make_event(EV_FIRE, s, tbl_fired[s],
                                                             dt[30:0], ST_RUNNING));
                                end
                            end
                            else
                            begin
                                tbl_state[s] = ST_FREE;
                                evs.push_back(make_event(EV_COMPLETE, s, tbl_fired[s],
                                                         '0, ST_FREE));
                            end
                        end
                        else if (tbl_state[s] == ST_PENDING)
                        begin
                            tbl_state[s] = ST_FREE;
                        end
                    end
                    last_tick_time = r.now_ticks;
                end
            end
            CMD_CREATE:
            begin
                found = -1;
                for (int s = 0; s < SLOTS && found < 0; s++)
                    if (tbl_state[s] == ST_FREE)
                        found = s;
                if (found < 0)
                    evs.push_back(make_event(EV_ERROR, 0, '0, '0, ST_FREE));
                else
                begin
                    tbl_state[found]    = ST_STOPPED;
                    tbl_period[found]   = r.period;
                    tbl_limit[found]    = r.repeat_limit;
                    tbl_fired[found]    = '0;
                    tbl_deadline[found] = '0;
                    evs.push_back(make_event(EV_ACK, found, '0, '0, ST_STOPPED));
                end
            end
            CMD_START:
            begin
                if (!in_range || tbl_state[id] == ST_FREE)
                    evs.push_back(make_event(EV_ERROR, id, '0, '0, ST_FREE));
                else
                begin
                    k = tbl_fired[id] + 1;
                    tbl_state[id]    = ST_RUNNING;
                    tbl_deadline[id] = r.now_ticks + 32'(64'(tbl_period[id]) * 64'(k));
                    evs.push_back(make_event(EV_ACK, id, tbl_fired[id], '0, ST_RUNNING));
                end
            end
            CMD_STOP:
            begin
                if (!in_range || tbl_state[id] == ST_FREE)
                    evs.push_back(make_event(EV_ERROR, id, '0, '0, ST_FREE));
                else
                begin
                    tbl_state[id] = ST_PENDING;
                    evs.push_back(make_event(EV_COMPLETE, id, tbl_fired[id], '0, ST_PENDING));
                end
            end
            CMD_STOP_ALL:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (tbl_state[s] != ST_FREE)
                    begin
                        tbl_state[s] = ST_FREE;
                        evs.push_back(make_event(EV_COMPLETE, s, tbl_fired[s], '0, ST_FREE));
                    end
                end
                if (evs.size() == 0)
                    evs.push_back(make_event(EV_ACK, 0, '0, '0, ST_FREE));
            end
            CMD_QUERY:
            begin
                if (!in_range)
                    evs.push_back(make_event(EV_ERROR, id, '0, '0, ST_FREE));
                else if (tbl_state[id] == ST_FREE)
                    evs.push_back(make_event(EV_ACK, id, '0, '0, ST_FREE));
                else
                    evs.push_back(make_event(EV_ACK, id, tbl_fired[id], '0, tbl_state[id]));
            end
            default:
            begin
                evs.push_back(make_event(EV_ERROR, id, '0, '0, ST_FREE));
            end
        endcase
        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
            awaited_events.push_back(evs[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_event(input mspt_rsp_t got);
        mspt_rsp_t want;
        if (awaited_events.size() == 0)
        begin
            mismatches++;
            $display("%0t: event with nothing awaited: kind %0d slot %0d total %0d",
                     $time, got.event_kind, got.slot_out, got.fire_total);
        end
        else
        begin
            want = awaited_events.pop_front();
            check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
            check_field("fire_total", want.fire_total, got.fire_total);
            check_field("lateness", 32'(want.lateness), 32'(got.lateness));
            check_field("slot_status", 32'(want.slot_status), 32'(got.slot_status));
            check_field("last", 32'(want.last), 32'(got.last));
            checked_events++;
            case (want.event_kind)
                EV_FIRE:     fire_events++;
                EV_COMPLETE: complete_events++;
                EV_ERROR:    error_events++;
                default:     ;
            endcase
        end
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    always @(posedge clk)
    begin
        if (calm_cycles > 0)
            calm_cycles <= calm_cycles - 1;
        else if ($urandom_range(0, 299) == 0)
            calm_cycles <= $urandom_range(50, 200);
    end

    // Command driver: predict on each transfer, then present the next command.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                timer_table_apply(req);
                sent_count++;
            end
            if (!(req_valid && req_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (cmd_queue.size() == 0)
                begin
                    req_valid <= 1'b0;
                end
                else if (cmd_queue[0].hold)
                begin
                    // hold off until every awaited event has come back
                    req_valid <= 1'b0;
                    if (awaited_events.size() == 0)
                        void'(cmd_queue.pop_front());
                end
                else
                begin
                    next_cmd = cmd_queue.pop_front();
                    req_valid <= 1'b1;
                    req       <= next_cmd.req;
                    send_gap = (calm_cycles > 0) ? 0 : pick_idle();
                end
            end
        end
    end

    // Event monitor: check each transfer, stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_event(rsp);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                stall_left = (calm_cycles == 0 && $urandom_range(0, 3) == 0) ? pick_idle() : 0;
                rsp_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d events still awaited",
                     $time, cycle_count, awaited_events.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic mspt_req_t rand_req();
        mspt_req_t r;
        r.command      = 3'($urandom_range(0, 7));
        r.slot_id      = 4'($urandom());
        r.now_ticks    = $urandom();
        r.period       = 31'($urandom());
        r.repeat_limit = 31'($urandom());
        return r;
    endfunction

    function automatic void push_cmd(input mspt_req_t r);
        timer_cmd_t c;
        c.hold = 1'b0;
        c.req  = r;
        // an unchanged tick time is ignored by the block; leave it out of the count
        if (r.command != CMD_TICK || r.now_ticks != gen_last_tick)
            issued_items++;
        if (r.command == CMD_TICK)
            gen_last_tick = r.now_ticks;
        cmd_queue.push_back(c);
    endfunction

    function automatic void push_fields(input logic [2:0] cmd, input int slot,
                                        input logic [31:0] now, input logic [30:0] per,
                                        input logic [30:0] lim);
        mspt_req_t r;
        r.command      = cmd;
        r.slot_id      = 4'(slot);
        r.now_ticks    = now;
        r.period       = per;
        r.repeat_limit = lim;
        push_cmd(r);
    endfunction

    function automatic void push_hold();
        timer_cmd_t c;
        c.hold = 1'b1;
        c.req  = '0;
        cmd_queue.push_back(c);
    endfunction

    function automatic logic [30:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 31'($urandom_range(0, 12));
        else if (r < 9)
            return 31'($urandom_range(13, 200));
        else
            return 31'($urandom());
    endfunction

    function automatic logic [30:0] pick_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6)
            return '0;
        else if (r < 17)
            return 31'($urandom_range(1, 4));
        else
            return 31'($urandom());
    endfunction

    function automatic void advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            ;
        else if (r < 68)
            gen_now = gen_now + $urandom_range(1, 8);
        else if (r < 98)
            gen_now = gen_now + $urandom_range(9, 40);
        else
            gen_now = gen_now + $urandom();
    endfunction

    function automatic void push_tick();
        mspt_req_t r;
        advance_clock();
        r = rand_req();
        r.command   = CMD_TICK;
        r.now_ticks = gen_now;
        push_cmd(r);
    endfunction

    // Well-formed run: mostly clear table, create timers in slots 0.., start, tick.
    function automatic void timer_burst();
        mspt_req_t r;
        int n;
        int steps;
        int pick;
        n = $urandom_range(1, 5);
        if ($urandom_range(0, 3) != 0)
        begin
            r = rand_req();
            r.command = CMD_STOP_ALL;
            push_cmd(r);
        end
        for (int i = 0; i < n; i++)
        begin
            r = rand_req();
            r.command      = CMD_CREATE;
            r.period       = pick_period();
            r.repeat_limit = pick_limit();
            push_cmd(r);
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) != 0)
            begin
                r = rand_req();
                r.command   = CMD_START;
                r.slot_id   = 4'(i);
                r.now_ticks = gen_now;
                push_cmd(r);
            end
        end
        steps = $urandom_range(3, 12);
        for (int t = 0; t < steps; t++)
        begin
            pick = $urandom_range(0, 9);
            r = rand_req();
            r.slot_id   = 4'($urandom_range(0, n));
            r.now_ticks = gen_now;
            if (pick < 7)
                push_tick();
            else
            begin
                r.command = (pick == 7) ? CMD_QUERY : (pick == 8) ? CMD_STOP : CMD_START;
                push_cmd(r);
            end
        end
    endfunction

    // Fill every slot, overflow once, then run a few of them.
    function automatic void table_fill();
        mspt_req_t r;
        r = rand_req();
        r.command = CMD_STOP_ALL;
        push_cmd(r);
        for (int i = 0; i <= SLOTS; i++)
        begin
            r = rand_req();
            r.command      = CMD_CREATE;
            r.period       = pick_period();
            r.repeat_limit = pick_limit();
            push_cmd(r);
        end
        for (int i = 0; i < 6; i++)
        begin
            r = rand_req();
            r.command   = ($urandom_range(0, 3) == 0) ? CMD_STOP : CMD_START;
            r.now_ticks = gen_now;
            push_cmd(r);
        end
        for (int i = 0; i < 4; i++)
            push_tick();
    endfunction

    initial
    begin
        int pick;

        // directed: error paths, a short schedule, wrap of the time base
        push_fields(CMD_TICK, 0, 32'd0, '0, '0);
        push_fields(CMD_QUERY, 0, '0, '0, '0);
        push_fields(CMD_QUERY, 15, '0, '0, '0);
        push_fields(CMD_STOP, 3, '0, '0, '0);
        push_fields(CMD_START, 5, '0, '0, '0);
        push_fields(CMD_STOP_ALL, 0, '0, '0, '0);
        push_fields(CMD_CREATE, 0, '0, 31'd10, 31'd2);
        push_fields(CMD_CREATE, 0, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_fields(CMD_CREATE, 0, '0, 31'd0, 31'd0);
        push_fields(CMD_TICK, 0, 32'd50, '0, '0);
        push_fields(CMD_START, 0, 32'd100, '0, '0);
        push_fields(CMD_START, 2, 32'd100, '0, '0);
        push_fields(CMD_TICK, 0, 32'd105, '0, '0);
        push_fields(CMD_TICK, 0, 32'd120, '0, '0);
        push_fields(CMD_TICK, 0, 32'd130, '0, '0);
        push_fields(CMD_TICK, 0, 32'd140, '0, '0);
        push_fields(CMD_STOP, 2, '0, '0, '0);
        push_fields(CMD_QUERY, 2, '0, '0, '0);
        push_fields(CMD_STOP, 2, '0, '0, '0);
        push_fields(CMD_START, 2, 32'hFFFF_FFF0, '0, '0);
        push_fields(CMD_START, 1, 32'hFFFF_FFFF, '0, '0);
        push_fields(CMD_TICK, 0, 32'hFFFF_FFFF, '0, '0);
        push_fields(CMD_TICK, 0, 32'd5, '0, '0);
        push_fields(CMD_RSVD_A, 9, '0, '0, '0);
        push_fields(CMD_RSVD_B, 15, '0, '0, '0);
        push_fields(CMD_STOP_ALL, 0, '0, '0, '0);
        push_hold();

        issued_items = 0;
        gen_now = $urandom();
        while (issued_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                timer_burst();
            else if (pick < 75)
                table_fill();
            else if (pick < 80)
                push_hold();
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_cmd(rand_req());
                    else
                        push_tick();
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        // sample between edges so the driver's updates have settled
        while (cmd_queue.size() != 0 || req_valid || awaited_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_events.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d awaited events never arrived", $time, awaited_events.size());
        end

        $display("Ran %0d timer commands; checked %0d events: %0d fires, %0d completes, %0d errors.",
                 sent_count, checked_events, fire_events, complete_events, error_events);
        $display("Field mismatches and stray events seen: %0d.", mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
